// File: rtl/mi3_pkg.sv
// Package for the 3x3 matrix inverse core: payload structs and datapath widths.
// No dependencies; every rtl file refers to it by scoped names.
package mi3_pkg;

  localparam int ELEM_W      = 16;             // Q8.8 matrix element
  localparam int PROD_W      = 32;             // 16x16 minor product
  localparam int COF_W       = 33;             // signed cofactor
  localparam int CMAG_W      = 32;             // cofactor magnitude
  localparam int TERM_W      = 49;             // row-0 element times cofactor
  localparam int DET_W       = 50;             // signed determinant, sum of three terms
  localparam int DMAG_W      = 49;             // determinant magnitude
  localparam int Q_W         = 32;             // quotient bits
  localparam int FRAC_SHIFT  = 25;             // 2^24 rescale plus the doubling for rounding
  localparam int NUM_W       = 58;             // 2*|cof|*2^24 + |det|
  localparam int DEN_W       = DMAG_W + 1;     // 2*|det|
  localparam int WIDE_W      = DEN_W + Q_W;    // shifted divisor in the divider
  localparam int NELEM       = 9;
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES  = Q_W + 1;        // overflow check plus one bit per stage
  localparam int PIPE_STAGES = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] r00;
    logic signed [Q_W-1:0] r01;
    logic signed [Q_W-1:0] r02;
    logic signed [Q_W-1:0] r10;
    logic signed [Q_W-1:0] r11;
    logic signed [Q_W-1:0] r12;
    logic signed [Q_W-1:0] r20;
    logic signed [Q_W-1:0] r21;
    logic signed [Q_W-1:0] r22;
    logic                  singular;
  } out_t;

endpackage

// File: rtl/matrix3x3_inverse_core.sv
// Channel | Handshake          | Payload
// in_     | in_valid/in_stall  | in_data  (mi3_pkg::in_t, nine Q8.8 elements)
// out_    | out_valid/out_stall| out_data (mi3_pkg::out_t, nine Q16.16, singular)
// One matrix per cycle sustained while in_stall is low; from accept to out_valid a matrix passes
// 5 front stages, 33 divider stages, 1 saturation stage and the output register.
// The per-bit restoring divider sets the depth. Reset clears all valid bits.
// A stalled output is held with a one-entry skid; the pipeline freezes once it fills.
// Top level of the 3x3 inverse; uses mi3_pkg, mi3_front and mi3_div.
module matrix3x3_inverse_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mi3_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mi3_pkg::out_t out_data
);

  localparam int NE = mi3_pkg::NELEM;
  localparam int PS = mi3_pkg::PIPE_STAGES;
  localparam int DS = mi3_pkg::DIV_STAGES;

  logic                      en;
  logic [PS-1:0]             vld_r, vld_nxt;
  logic [mi3_pkg::NUM_W-1:0] num [NE];
  logic [mi3_pkg::DEN_W-1:0] den;
  logic [NE-1:0]             neg;
  logic                      sing;
  logic [mi3_pkg::Q_W-1:0]   q    [NE];
  logic [NE-1:0]             ovf;
  logic [NE-1:0]             qneg;
  logic [DS-1:0]             sing_r;
  logic [mi3_pkg::Q_W-1:0]   res  [NE];
  mi3_pkg::out_t             sat_nxt, sat_r;
  mi3_pkg::out_t             out_r, out_nxt, skid_r, skid_nxt;
  logic                      out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic                      slot_free, inc_v;

  assign en       = !skid_v_r;
  assign in_stall = !en;

  mi3_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .num_o   (num),
    .den_o   (den),
    .neg_o   (neg),
    .sing_o  (sing)
  );

  for (genvar ge = 0; ge < NE; ge++) begin : g_div
    mi3_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num[ge]),
      .den_i (den),
      .neg_i (neg[ge]),
      .q_o   (q[ge]),
      .ovf_o (ovf[ge]),
      .neg_o (qneg[ge])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[DS-2:0], sing};
    end
  end

  // apply sign and clamp to the Q16.16 range; a singular matrix gives all zeros
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (sing_r[DS-1]) begin
        res[k] = '0;
      end else if (qneg[k]) begin
        res[k] = (ovf[k] || q[k] > mi3_pkg::NEG_MAG) ? mi3_pkg::NEG_MAG : -q[k];
      end else begin
        res[k] = (ovf[k] || q[k][mi3_pkg::Q_W-1]) ? mi3_pkg::POS_MAX : q[k];
      end
    end
    sat_nxt.r00      = res[0];
    sat_nxt.r01      = res[1];
    sat_nxt.r02      = res[2];
    sat_nxt.r10      = res[3];
    sat_nxt.r11      = res[4];
    sat_nxt.r12      = res[5];
    sat_nxt.r20      = res[6];
    sat_nxt.r21      = res[7];
    sat_nxt.r22      = res[8];
    sat_nxt.singular = sing_r[DS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[PS-2:0], in_valid};
    end
  end

  // output register with one skid entry
  assign slot_free = !out_v_r || !out_stall;
  assign inc_v     = en && vld_r[PS-1];

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (slot_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt  = inc_v;
        out_nxt    = sat_r;
      end
    end else if (inc_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/mi3_front.sv
// Front end of the inverse pipeline: minors, cofactors, determinant, divider operands.
// Five register stages, all advanced by one enable. Depends on mi3_pkg.
module mi3_front (
  input  logic                        clk,
  input  logic                        en,
  input  mi3_pkg::in_t                in_data,
  output logic [mi3_pkg::NUM_W-1:0]   num_o [mi3_pkg::NELEM],
  output logic [mi3_pkg::DEN_W-1:0]   den_o,
  output logic [mi3_pkg::NELEM-1:0]   neg_o,
  output logic                        sing_o
);

  logic signed [mi3_pkg::ELEM_W-1:0] m [3][3];
  logic signed [mi3_pkg::PROD_W-1:0] p0_r [3][3];
  logic signed [mi3_pkg::PROD_W-1:0] p1_r [3][3];
  logic signed [mi3_pkg::ELEM_W-1:0] m0a_r [3];
  logic signed [mi3_pkg::ELEM_W-1:0] m0b_r [3];
  logic signed [mi3_pkg::COF_W-1:0]  cof_r [3][3];
  logic signed [mi3_pkg::COF_W-1:0]  cofb_r [3][3];
  logic signed [mi3_pkg::TERM_W-1:0] term_r [3];
  logic signed [mi3_pkg::DET_W-1:0]  det_r;
  logic [mi3_pkg::CMAG_W-1:0]        cmag_r [3][3];
  logic                              csgn_r [3][3];
  logic [mi3_pkg::DMAG_W-1:0]        dmag;
  logic [mi3_pkg::NUM_W-1:0]         num_r [mi3_pkg::NELEM];
  logic [mi3_pkg::DEN_W-1:0]         den_r;
  logic [mi3_pkg::NELEM-1:0]         neg_r;
  logic                              sing_r;

  always_comb begin
    m[0][0] = in_data.a00; m[0][1] = in_data.a01; m[0][2] = in_data.a02;
    m[1][0] = in_data.a10; m[1][1] = in_data.a11; m[1][2] = in_data.a12;
    m[2][0] = in_data.a20; m[2][1] = in_data.a21; m[2][2] = in_data.a22;
  end

  // cyclic indexing yields the signed cofactor directly
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    localparam int I1 = (gi + 1) % 3;
    localparam int I2 = (gi + 2) % 3;
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          p0_r[gi][gj]   <= m[I1][J1] * m[I2][J2];
          p1_r[gi][gj]   <= m[I1][J2] * m[I2][J1];
          cof_r[gi][gj]  <= mi3_pkg::COF_W'(p0_r[gi][gj]) - mi3_pkg::COF_W'(p1_r[gi][gj]);
          cofb_r[gi][gj] <= cof_r[gi][gj];
          cmag_r[gi][gj] <= cofb_r[gi][gj][mi3_pkg::COF_W-1] ?
                            mi3_pkg::CMAG_W'(-cofb_r[gi][gj]) :
                            mi3_pkg::CMAG_W'(cofb_r[gi][gj]);
          csgn_r[gi][gj] <= cofb_r[gi][gj][mi3_pkg::COF_W-1];
        end
      end
    end
  end

  for (genvar gj = 0; gj < 3; gj++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        m0a_r[gj]  <= m[0][gj];
        m0b_r[gj]  <= m0a_r[gj];
        term_r[gj] <= mi3_pkg::TERM_W'(m0b_r[gj]) * mi3_pkg::TERM_W'(cof_r[0][gj]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= mi3_pkg::DET_W'(term_r[0]) + mi3_pkg::DET_W'(term_r[1])
             + mi3_pkg::DET_W'(term_r[2]);
    end
  end

  assign dmag = det_r[mi3_pkg::DET_W-1] ? mi3_pkg::DMAG_W'(-det_r) : mi3_pkg::DMAG_W'(det_r);

  // inverse element (i,j) takes cofactor (j,i): transpose here
  for (genvar gi = 0; gi < 3; gi++) begin : g_oi
    for (genvar gj = 0; gj < 3; gj++) begin : g_oj
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[gi*3+gj] <= (mi3_pkg::NUM_W'(cmag_r[gj][gi]) << mi3_pkg::FRAC_SHIFT)
                          + mi3_pkg::NUM_W'(dmag);
          neg_r[gi*3+gj] <= csgn_r[gj][gi] ^ det_r[mi3_pkg::DET_W-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= {dmag, 1'b0};
      sing_r <= (det_r == '0);
    end
  end

  assign num_o  = num_r;
  assign den_o  = den_r;
  assign neg_o  = neg_r;
  assign sing_o = sing_r;

endmodule

// File: rtl/mi3_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Carries the result sign alongside. Depends on mi3_pkg.
module mi3_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [mi3_pkg::NUM_W-1:0] num_i,
  input  logic [mi3_pkg::DEN_W-1:0] den_i,
  input  logic                      neg_i,
  output logic [mi3_pkg::Q_W-1:0]   q_o,
  output logic                      ovf_o,
  output logic                      neg_o
);

  localparam int S = mi3_pkg::DIV_STAGES;

  logic [mi3_pkg::NUM_W-1:0] rem_r [S];
  logic [mi3_pkg::DEN_W-1:0] den_r [S];
  logic [mi3_pkg::Q_W-1:0]   q_r   [S];
  logic                      ovf_r [S];
  logic                      neg_r [S];

  // quotient reaches 2^32 when num >= den * 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      ovf_r[0] <= mi3_pkg::DEN_W'(num_i[mi3_pkg::NUM_W-1:mi3_pkg::Q_W]) >= den_i;
      neg_r[0] <= neg_i;
    end
  end

  for (genvar gs = 1; gs < S; gs++) begin : g_step
    localparam int K = mi3_pkg::Q_W - gs;
    logic [mi3_pkg::WIDE_W-1:0] dsh;
    logic [mi3_pkg::WIDE_W-1:0] rw;
    logic                       ge;
    assign dsh = mi3_pkg::WIDE_W'(den_r[gs-1]) << K;
    assign rw  = mi3_pkg::WIDE_W'(rem_r[gs-1]);
    assign ge  = rw >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gs]    <= ge ? mi3_pkg::NUM_W'(rw - dsh) : rem_r[gs-1];
        q_r[gs]      <= q_r[gs-1] | (mi3_pkg::Q_W'(ge) << K);
        den_r[gs]    <= den_r[gs-1];
        ovf_r[gs]    <= ovf_r[gs-1];
        neg_r[gs]    <= neg_r[gs-1];
      end
    end
  end

  assign q_o   = q_r[S-1];
  assign ovf_o = ovf_r[S-1];
  assign neg_o = neg_r[S-1];

endmodule

// File: rtl/mi3_checker.sv
// Port-level checks for matrix3x3_inverse_core, attached by bind.
// Depends on mi3_pkg and the top level's ports.
module mi3_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input mi3_pkg::out_t out_data
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.r00 == 0 && out_data.r01 == 0 && out_data.r02 == 0 &&
      out_data.r10 == 0 && out_data.r11 == 0 && out_data.r12 == 0 &&
      out_data.r20 == 0 && out_data.r21 == 0 && out_data.r22 == 0)
    else $error("singular result with nonzero elements");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  // input backpressure only arises behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (.*);
